// ===== design/bpfi_pkg.sv =====
// Package for the ball position block: formats, latencies, tables and rounding helpers.
package bpfi_pkg;

    // Number of CORDIC rotations, one pipeline stage each (at most 25, the size of the arctangent table).
    localparam int CORDIC_STEPS = 16;

    // Word widths.
    localparam int ANG_W   = 33;              // bearing and half angle, signed Q.30
    localparam int Z_W     = 34;              // CORDIC residual angle
    localparam int XY_W    = 33;              // CORDIC vector, signed Q.30
    localparam int NUM_W   = 50;              // radius times cosine
    localparam int DIV_QBITS = 31;            // quotient bits below the saturation limit
    localparam int PROD_W  = 65;              // Q16.16 times Q.30 product

    // Latencies in cycles.
    localparam int CORDIC_LAT = CORDIC_STEPS + 2;
    localparam int DIV_LAT    = DIV_QBITS + 3;
    localparam int TOTAL_LAT  = CORDIC_LAT + DIV_LAT + 5;

    localparam logic signed [XY_W-1:0] CORDIC_GAIN = XY_W'(652032874);
    localparam logic signed [Z_W-1:0]  PI_Q30      = Z_W'(64'd3373259426);
    localparam logic signed [Z_W-1:0]  HALF_PI_Q30 = Z_W'(64'd1686629713);
    localparam logic [31:0]            RANGE_MAX   = 32'h7FFF_FFFF;

    // Register indexes of the configuration port.
    typedef enum logic [1:0] {
        CFG_HFOV   = 2'd0,
        CFG_VFOV   = 2'd1,
        CFG_RADIUS = 2'd2,
        CFG_SPARE  = 2'd3
    } cfg_idx_t;

    // Range from the divider with its saturation flag.
    typedef struct packed {
        logic [31:0] range_val;
        logic        ovf;
    } range_t;

    // Arctangent of 2^-i in Q.30, truncated.
    function automatic logic signed [Z_W-1:0] atan_q30(input int i);
        logic [31:0] v;
        unique case (i)
            0:  v = 32'h3243F6A8;
            1:  v = 32'h1DAC6705;
            2:  v = 32'h0FADBAFC;
            3:  v = 32'h07F56EA6;
            4:  v = 32'h03FEAB76;
            5:  v = 32'h01FFD55B;
            6:  v = 32'h00FFFAAA;
            7:  v = 32'h007FFF55;
            8:  v = 32'h003FFFEA;
            9:  v = 32'h001FFFFD;
            10: v = 32'h000FFFFF;
            11: v = 32'h0007FFFF;
            12: v = 32'h0003FFFF;
            13: v = 32'h0001FFFF;
            14: v = 32'h0000FFFF;
            15: v = 32'h00007FFF;
            16: v = 32'h00003FFF;
            17: v = 32'h00001FFF;
            18: v = 32'h00000FFF;
            19: v = 32'h000007FF;
            20: v = 32'h000003FF;
            21: v = 32'h000001FF;
            22: v = 32'h000000FF;
            23: v = 32'h0000007F;
            24: v = 32'h0000003F;
            default: v = 32'h0;
        endcase
        return $signed({{(Z_W-32){1'b0}}, v});
    endfunction

    // Round a Q.30 product to nearest (ties upward) and clamp to 32 bits.
    function automatic logic [31:0] round_q30(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] t;
        t = (p + (PROD_W'(1) <<< 29)) >>> 30;
        if (t > $signed({{(PROD_W-32){1'b0}}, 32'h7FFF_FFFF})) begin
            return 32'h7FFF_FFFF;
        end else if (t < $signed({{(PROD_W-32){1'b1}}, 32'h8000_0000})) begin
            return 32'h8000_0000;
        end else begin
            return t[31:0];
        end
    endfunction

endpackage

// ===== design/bpfi_cordic.sv =====
// Pipelined CORDIC giving the cosine and sine of a Q.30 angle.
module bpfi_cordic (
    input  logic                           aclk,
    input  logic                           en,
    input  logic signed [bpfi_pkg::ANG_W-1:0] angle,
    output logic signed [bpfi_pkg::XY_W-1:0]  cos_out,
    output logic signed [bpfi_pkg::XY_W-1:0]  sin_out
);
    import bpfi_pkg::*;

    logic signed [XY_W-1:0] x_reg [CORDIC_STEPS+1];
    logic signed [XY_W-1:0] y_reg [CORDIC_STEPS+1];
    logic signed [Z_W-1:0]  z_reg [CORDIC_STEPS+1];
    logic                   flip_reg [CORDIC_STEPS+1];
    logic signed [XY_W-1:0] cos_reg;
    logic signed [XY_W-1:0] sin_reg;
    logic signed [Z_W-1:0]  a_ext;
    logic signed [Z_W-1:0]  z_next;
    logic                   flip_next;

    // Fold angles beyond a quarter turn back by half a turn.
    always_comb begin
        a_ext = {angle[ANG_W-1], angle};
        if (a_ext > HALF_PI_Q30) begin
            z_next    = a_ext - PI_Q30;
            flip_next = 1'b1;
        end else if (a_ext < -HALF_PI_Q30) begin
            z_next    = a_ext + PI_Q30;
            flip_next = 1'b1;
        end else begin
            z_next    = a_ext;
            flip_next = 1'b0;
        end
    end

    // One rotation per stage; a zero residual counts as positive.
    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0]    <= CORDIC_GAIN;
            y_reg[0]    <= '0;
            z_reg[0]    <= z_next;
            flip_reg[0] <= flip_next;
            for (int k = 0; k < CORDIC_STEPS; k++) begin
                flip_reg[k+1] <= flip_reg[k];
                if (!z_reg[k][Z_W-1]) begin
                    x_reg[k+1] <= x_reg[k] - (y_reg[k] >>> k);
                    y_reg[k+1] <= y_reg[k] + (x_reg[k] >>> k);
                    z_reg[k+1] <= z_reg[k] - atan_q30(k);
                end else begin
                    x_reg[k+1] <= x_reg[k] + (y_reg[k] >>> k);
                    y_reg[k+1] <= y_reg[k] - (x_reg[k] >>> k);
                    z_reg[k+1] <= z_reg[k] + atan_q30(k);
                end
            end
            cos_reg <= flip_reg[CORDIC_STEPS] ? -x_reg[CORDIC_STEPS] : x_reg[CORDIC_STEPS];
            sin_reg <= flip_reg[CORDIC_STEPS] ? -y_reg[CORDIC_STEPS] : y_reg[CORDIC_STEPS];
        end
    end

    assign cos_out = cos_reg;
    assign sin_out = sin_reg;

endmodule

// ===== design/bpfi_div.sv =====
// Pipelined range divider: radius times cosine over sine, with saturation.
module bpfi_div (
    input  logic                              aclk,
    input  logic                              en,
    input  logic                              zero_size,
    input  logic [15:0]                       radius,
    input  logic signed [bpfi_pkg::XY_W-1:0]  hc,
    input  logic signed [bpfi_pkg::XY_W-1:0]  hs,
    output bpfi_pkg::range_t                  result
);
    import bpfi_pkg::*;

    // First stage: product and the invalid-sine test.
    logic signed [NUM_W-1:0] num_reg;
    logic signed [XY_W-1:0]  hs_reg;
    logic                    bad0_reg;

    // Long division stages.
    logic [31:0]            rem_reg  [DIV_QBITS+1];
    logic [DIV_QBITS-1:0]   low_reg  [DIV_QBITS+1];
    logic [DIV_QBITS-1:0]   quo_reg  [DIV_QBITS+1];
    logic [31:0]            dvs_reg  [DIV_QBITS+1];
    logic                   neg_reg  [DIV_QBITS+1];
    logic                   big_reg  [DIV_QBITS+1];
    logic                   bad_reg  [DIV_QBITS+1];
    range_t                 res_reg;

    logic [NUM_W-1:0] mag;
    logic [NUM_W-1:0] mag_hi;
    logic [31:0]      dvs;

    always_comb begin
        mag    = num_reg[NUM_W-1] ? NUM_W'(-num_reg) : NUM_W'(num_reg);
        mag_hi = mag >> DIV_QBITS;
        dvs    = hs_reg[31:0];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            num_reg  <= $signed({1'b0, radius}) * hc;
            hs_reg   <= hs;
            bad0_reg <= zero_size || hs[XY_W-1] || (hs == '0);

            // Set up: sign, magnitude and the early saturation test.
            rem_reg[0] <= 32'(mag_hi);
            low_reg[0] <= mag[DIV_QBITS-1:0];
            quo_reg[0] <= '0;
            dvs_reg[0] <= dvs;
            neg_reg[0] <= num_reg[NUM_W-1];
            big_reg[0] <= mag_hi >= {{(NUM_W-32){1'b0}}, dvs};
            bad_reg[0] <= bad0_reg;

            // One quotient bit per stage.
            for (int k = 0; k < DIV_QBITS; k++) begin
                logic [32:0] trial;
                trial = {rem_reg[k], low_reg[k][DIV_QBITS-1]};
                if (trial >= {1'b0, dvs_reg[k]}) begin
                    rem_reg[k+1] <= 32'(trial - {1'b0, dvs_reg[k]});
                    quo_reg[k+1] <= {quo_reg[k][DIV_QBITS-2:0], 1'b1};
                end else begin
                    rem_reg[k+1] <= trial[31:0];
                    quo_reg[k+1] <= {quo_reg[k][DIV_QBITS-2:0], 1'b0};
                end
                low_reg[k+1] <= {low_reg[k][DIV_QBITS-2:0], 1'b0};
                dvs_reg[k+1] <= dvs_reg[k];
                neg_reg[k+1] <= neg_reg[k];
                big_reg[k+1] <= big_reg[k];
                bad_reg[k+1] <= bad_reg[k];
            end

            // Sign and saturation.
            if (bad_reg[DIV_QBITS]) begin
                res_reg.range_val <= RANGE_MAX;
                res_reg.ovf       <= 1'b1;
            end else if (big_reg[DIV_QBITS]) begin
                res_reg.range_val <= neg_reg[DIV_QBITS] ? -RANGE_MAX : RANGE_MAX;
                res_reg.ovf       <= 1'b1;
            end else begin
                res_reg.range_val <= neg_reg[DIV_QBITS] ? -{1'b0, quo_reg[DIV_QBITS]}
                                                        : {1'b0, quo_reg[DIV_QBITS]};
                res_reg.ovf       <= 1'b0;
            end
        end
    end

    assign result = res_reg;

endmodule

// ===== design/ball_position_from_image.sv =====
// Top level: camera-frame ball position from normalised image detections.
//
//  Channel | Ports                          | Content
//  --------+--------------------------------+------------------------------------------
//  input   | s_tvalid s_tready s_tdata[47:0]| norm_x, norm_y, norm_size
//  result  | m_tvalid m_tready m_tdata[95:0]| pos_x, pos_y, pos_z; m_tuser: range_overflow
//  config  | cfg_valid cfg_ready            | cfg_index, cfg_data (16-bit register write)
//
// One detection is accepted per cycle while no result waits to be taken; each passes the entry stage,
// the CORDIC stages (one per rotation), the one-bit-per-stage range divider and the component stages.
// The whole pipeline advances together and holds while a result waits to be taken.
// Reset (aresetn low, synchronous) empties the pipeline and loads the default registers.
module ball_position_from_image (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // norm_x [15:0], norm_y [31:16], norm_size [47:32]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // pos_x [31:0], pos_y [63:32], pos_z [95:64]
    output logic [0:0]  m_tuser,   // range_overflow [0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import bpfi_pkg::*;

    localparam int LAST = TOTAL_LAT - 1;

    logic [15:0] hfov_reg;
    logic [15:0] vfov_reg;
    logic [15:0] radius_reg;

    logic [TOTAL_LAT-1:0] valid_reg;
    logic                 adv;

    // Entry stage.
    logic [31:0]             full_reg;
    logic signed [ANG_W-1:0] yang_reg;
    logic signed [ANG_W-1:0] xang_reg;
    logic signed [ANG_W-1:0] half_ang;

    // CORDIC outputs.
    logic signed [XY_W-1:0] hc, hs, yc, ys, xc, xs;

    // Delay lines matching the CORDIC and divider latencies.
    logic                   zero_dly [CORDIC_LAT];
    logic signed [XY_W-1:0] yc_dly   [DIV_LAT];
    logic signed [XY_W-1:0] ys_dly   [DIV_LAT];
    logic signed [XY_W-1:0] xc_dly   [DIV_LAT+2];
    logic signed [XY_W-1:0] xs_dly   [DIV_LAT+2];

    range_t             div_res;
    logic signed [31:0] range_d;

    // Component stages.
    logic signed [PROD_W-1:0] py_reg, pys_reg, px_reg, pz_reg;
    logic signed [31:0]       proj_reg;
    logic [31:0]              posy2_reg, posy3_reg;
    logic                     ovf1_reg, ovf2_reg, ovf3_reg;
    logic [31:0]              pos_x_reg, pos_y_reg, pos_z_reg;
    logic                     ovf_out_reg;

    // The pipeline moves whenever the output register is free or being emptied.
    assign adv       = !valid_reg[LAST] || m_tready;
    assign s_tready  = adv;
    assign cfg_ready = 1'b1;

    // Configuration registers; a write to the spare index is ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hfov_reg   <= 16'd17842;
            vfov_reg   <= 16'd13382;
            radius_reg <= 16'd2163;
        end else if (cfg_valid) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_HFOV:   hfov_reg   <= cfg_data;
                CFG_VFOV:   vfov_reg   <= cfg_data;
                CFG_RADIUS: radius_reg <= cfg_data;
                CFG_SPARE:  ;
                default:    ;
            endcase
        end
    end

    // Valid bits travel alongside the data.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (adv) begin
            valid_reg <= {valid_reg[TOTAL_LAT-2:0], s_tvalid};
        end
    end

    // Angular size and the two bearings.
    always_ff @(posedge aclk) begin
        if (adv) begin
            full_reg <= s_tdata[47:32] * hfov_reg;
            yang_reg <= $signed(s_tdata[31:16]) * $signed({1'b0, vfov_reg});
            xang_reg <= $signed(s_tdata[15:0]) * $signed({1'b0, hfov_reg});
        end
    end

    assign half_ang = $signed({2'b00, full_reg[31:1]});

    bpfi_cordic u_cordic_h (
        .aclk(aclk), .en(adv), .angle(half_ang), .cos_out(hc), .sin_out(hs)
    );
    bpfi_cordic u_cordic_y (
        .aclk(aclk), .en(adv), .angle(yang_reg), .cos_out(yc), .sin_out(ys)
    );
    bpfi_cordic u_cordic_x (
        .aclk(aclk), .en(adv), .angle(xang_reg), .cos_out(xc), .sin_out(xs)
    );

    // Alignment delays.
    always_ff @(posedge aclk) begin
        if (adv) begin
            zero_dly[0] <= (full_reg == '0);
            for (int i = 1; i < CORDIC_LAT; i++) begin
                zero_dly[i] <= zero_dly[i-1];
            end
            yc_dly[0] <= yc;
            ys_dly[0] <= ys;
            for (int i = 1; i < DIV_LAT; i++) begin
                yc_dly[i] <= yc_dly[i-1];
                ys_dly[i] <= ys_dly[i-1];
            end
            xc_dly[0] <= xc;
            xs_dly[0] <= xs;
            for (int i = 1; i < DIV_LAT + 2; i++) begin
                xc_dly[i] <= xc_dly[i-1];
                xs_dly[i] <= xs_dly[i-1];
            end
        end
    end

    bpfi_div u_div (
        .aclk(aclk), .en(adv), .zero_size(zero_dly[CORDIC_LAT-1]),
        .radius(radius_reg), .hc(hc), .hs(hs), .result(div_res)
    );

    assign range_d = div_res.range_val;

    // Split the range into the ground projection and y, then into x and z.
    always_ff @(posedge aclk) begin
        if (adv) begin
            py_reg    <= range_d * yc_dly[DIV_LAT-1];
            pys_reg   <= range_d * ys_dly[DIV_LAT-1];
            ovf1_reg  <= div_res.ovf;

            proj_reg  <= round_q30(py_reg);
            posy2_reg <= round_q30(pys_reg);
            ovf2_reg  <= ovf1_reg;

            px_reg    <= proj_reg * xs_dly[DIV_LAT+1];
            pz_reg    <= proj_reg * xc_dly[DIV_LAT+1];
            posy3_reg <= posy2_reg;
            ovf3_reg  <= ovf2_reg;

            pos_x_reg   <= round_q30(px_reg);
            pos_z_reg   <= round_q30(pz_reg);
            pos_y_reg   <= posy3_reg;
            ovf_out_reg <= ovf3_reg;
        end
    end

    assign m_tvalid = valid_reg[LAST];
    assign m_tdata  = {pos_z_reg, pos_y_reg, pos_x_reg};
    assign m_tuser  = ovf_out_reg;

    // An accepted transfer enters the first stage.
    a_enter: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> valid_reg[0])
        else $error("accepted transfer did not enter the pipeline");

    // A stalled pipeline keeps every item in place.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(valid_reg))
        else $error("pipeline moved while stalled");

    // Nothing is taken in while the output register is held.
    a_block: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg[LAST] && !m_tready |-> !s_tready)
        else $error("input accepted during an output stall");

endmodule

// ===== test/ball_position_checker.sv =====
// Checker for the ball position block: predicts each result and compares it on the output.
`timescale 1ns / 1ps

module ball_position_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [95:0] m_tdata,
    input  logic [0:0]  m_tuser,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output int          fail_count,
    output int          pending
);
    import bpfi_pkg::*;

    typedef struct packed {
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] pos_z;
        logic        ovf;
    } position_t;

    localparam longint GAIN_Q30  = 652032874;
    localparam longint PI_L      = 64'sd3373259426;
    localparam longint HALF_PI_L = 64'sd1686629713;
    localparam longint DIST_MAX  = 64'sd2147483647;

    logic [15:0] hfov_reg, vfov_reg, radius_reg;
    position_t   position_queue[$];

    function automatic longint sat32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // Q16.16 times Q.30, rounded to nearest; >>> on longint is a floor.
    function automatic longint scale_q30(input longint a, input longint b);
        return sat32((a * b + (64'sd1 <<< 29)) >>> 30);
    endfunction

    // Rotation-mode CORDIC with the quadrant fold beyond half pi.
    task automatic rotate(input longint ang, output longint c, output longint s);
        longint x, y, z, dx, dy;
        bit     flip;
        x = GAIN_Q30;
        y = 0;
        flip = 0;
        if (ang > HALF_PI_L) begin
            ang = ang - PI_L;
            flip = 1;
        end else if (ang < -HALF_PI_L) begin
            ang = ang + PI_L;
            flip = 1;
        end
        z = ang;
        for (int i = 0; i < CORDIC_STEPS && i < 25; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - longint'(atan_q30(i));
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + longint'(atan_q30(i));
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    task automatic predict_position(input logic [47:0] data, output position_t res);
        longint nx, ny, size, full, hc, hs, yc, ys, xc, xs, range_m, proj;
        nx   = longint'($signed(data[15:0]));
        ny   = longint'($signed(data[31:16]));
        size = longint'(data[47:32]);
        full = size * longint'(hfov_reg);
        res.ovf = 0;
        rotate(full >>> 1, hc, hs);
        if (full == 0 || hs <= 0) begin
            range_m = DIST_MAX;
            res.ovf = 1;
        end else begin
            // SystemVerilog division truncates toward zero.
            range_m = (longint'(radius_reg) * hc) / hs;
            if (range_m > DIST_MAX) begin
                range_m = DIST_MAX;
                res.ovf = 1;
            end else if (range_m < -DIST_MAX) begin
                range_m = -DIST_MAX;
                res.ovf = 1;
            end
        end
        rotate(ny * longint'(vfov_reg), yc, ys);
        rotate(nx * longint'(hfov_reg), xc, xs);
        proj = scale_q30(range_m, yc);
        res.pos_x = 32'(scale_q30(proj, xs));
        res.pos_y = 32'(scale_q30(range_m, ys));
        res.pos_z = 32'(scale_q30(proj, xc));
    endtask

    // Register shadow, input predictions and output comparison.
    always @(posedge aclk) begin
        position_t want, got;
        if (!aresetn) begin
            hfov_reg   <= 16'd17842;
            vfov_reg   <= 16'd13382;
            radius_reg <= 16'd2163;
            fail_count <= 0;
            pending    <= 0;
            position_queue.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_idx_t'(cfg_index))
                    CFG_HFOV:   hfov_reg   <= cfg_data;
                    CFG_VFOV:   vfov_reg   <= cfg_data;
                    CFG_RADIUS: radius_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                predict_position(s_tdata, want);
                position_queue.push_back(want);
            end
            if (m_tvalid && m_tready) begin
                got = {m_tdata[31:0], m_tdata[63:32], m_tdata[95:64], m_tuser[0]};
                if (position_queue.size() == 0) begin
                    fail_count <= fail_count + 1;
                    if (fail_count < 10)
                        $display("unexpected result transfer %h", got);
                end else begin
                    want = position_queue.pop_front();
                    if (got !== want) begin
                        fail_count <= fail_count + 1;
                        if (fail_count < 10)
                            $display("mismatch: x %h/%h y %h/%h z %h/%h ovf %b/%b (exp/act)",
                                     want.pos_x, got.pos_x, want.pos_y, got.pos_y,
                                     want.pos_z, got.pos_z, want.ovf, got.ovf);
                    end
                end
            end
            pending <= position_queue.size();
        end
    end

endmodule

// ===== test/ball_position_from_image_test.sv =====
// Testbench top for the ball position block: stimulus, stalls and the verdict.
`timescale 1ns / 1ps

module ball_position_from_image_test;
    import bpfi_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [95:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;
    int          fail_count;
    int          pending;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          hold_cycles = 0;

    always #4 aclk = ~aclk;

    ball_position_from_image u_top (.*);

    ball_position_checker u_checker (.*);

    // Receiver: random stalls plus a counted long hold-off when asked.
    always @(negedge aclk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic write_reg(input cfg_idx_t idx, input logic [15:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // One input transfer, with a random gap beforehand.
    task automatic send_detection(input logic [15:0] nx, input logic [15:0] ny,
                                  input logic [15:0] size);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {size, ny, nx};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic drain;
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (TOTAL_LAT + 10) @(posedge aclk);
    endtask

    function automatic logic [15:0] rand_size();
        // Mostly small sizes, which give realistic ranges; sometimes anything.
        case ($urandom_range(3))
            0: return 16'($urandom);
            1: return 16'($urandom_range(0, 16));
            default: return 16'($urandom_range(1, 4000));
        endcase
    endfunction

    task automatic random_phase(input int count, input int idle, input int stall);
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        repeat (count) send_detection(16'($urandom), 16'($urandom), rand_size());
        drain();
    endtask

    logic [15:0] edge_vals[6] = '{16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h0001, 16'h4000};

    initial begin
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: field extremes, zero size and saturating ranges at reset settings.
        foreach (edge_vals[i]) send_detection(edge_vals[i], edge_vals[5 - i], 16'h0000);
        foreach (edge_vals[i]) send_detection(edge_vals[i], edge_vals[i], edge_vals[i]);
        send_detection(16'h8000, 16'h7FFF, 16'h0001);
        send_detection(16'h7FFF, 16'h8000, 16'hFFFF);
        drain();

        // Widest fields of view: half angle beyond half pi gives negative ranges.
        write_reg(CFG_HFOV, 16'hFFFF);
        write_reg(CFG_VFOV, 16'hFFFF);
        write_reg(CFG_RADIUS, 16'hFFFF);
        write_reg(CFG_SPARE, 16'h1234);
        foreach (edge_vals[i]) send_detection(edge_vals[i], edge_vals[i], edge_vals[5 - i]);
        send_detection(16'h8000, 16'h8000, 16'hC000);
        send_detection(16'h7FFF, 16'h7FFF, 16'h9000);
        random_phase(150, 0, 0);

        // Narrowest settings.
        write_reg(CFG_HFOV, 16'd1);
        write_reg(CFG_VFOV, 16'd1);
        write_reg(CFG_RADIUS, 16'd1);
        random_phase(150, 82, 0);

        // Upper ends of the stated ranges.
        write_reg(CFG_HFOV, 16'd51471);
        write_reg(CFG_VFOV, 16'd51471);
        write_reg(CFG_RADIUS, 16'd65535);
        random_phase(200, 0, 82);

        // Long receiver hold-off while the sender keeps offering.
        write_reg(CFG_HFOV, 16'd17842);
        write_reg(CFG_VFOV, 16'd13382);
        write_reg(CFG_RADIUS, 16'd2163);
        send_idle_pct = 0;
        @(negedge aclk);
        hold_cycles <= 300;
        recv_stall_pct = 0;
        repeat (200) send_detection(16'($urandom), 16'($urandom), rand_size());
        drain();

        // Random settings across the remaining phases.
        for (int p = 0; p < 4; p++) begin
            write_reg(CFG_HFOV, 16'($urandom));
            write_reg(CFG_VFOV, 16'($urandom));
            write_reg(CFG_RADIUS, 16'($urandom));
            random_phase(250, (p == 1) ? 82 : (p == 3) ? 27 : 0,
                         (p == 2) ? 82 : (p == 3) ? 27 : 0);
        end

        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #20ms;
        $display("status: fail");
        $finish;
    end

endmodule
